// ===== rtl/sm4_pkg.sv =====
package sm4_pkg;

  localparam int RoundCount = 32;
  localparam int CntWidth   = $clog2(RoundCount);

  typedef logic [31:0]         word_t;
  typedef logic [CntWidth-1:0] cnt_t;
  typedef logic [1:0]          cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_WORD0 = 2'd0;
  localparam cfg_idx_t CFG_KEY_WORD1 = 2'd1;
  localparam cfg_idx_t CFG_KEY_WORD2 = 2'd2;
  localparam cfg_idx_t CFG_KEY_WORD3 = 2'd3;

  localparam cnt_t LAST_ROUND = cnt_t'(RoundCount - 1);

  localparam word_t FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  typedef struct packed {
    logic load_key;
    logic load_block;
    logic round_en;
    logic key_mode;
    logic out_load;
    cnt_t cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic key_written;
  } dp_stat_t;

  function automatic word_t rotl(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t tau(input word_t x);
    word_t r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = SBOX[x[8*b +: 8]];
    end
    return r;
  endfunction

  function automatic word_t l_data(input word_t s);
    return s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
  endfunction

  function automatic word_t l_key(input word_t s);
    return s ^ rotl(s, 13) ^ rotl(s, 23);
  endfunction

  // byte j of ck(i), msb first: (4*i + j) * 7 mod 256
  function automatic word_t ck_word(input cnt_t i);
    word_t      r;
    logic [7:0] n;
    for (int j = 0; j < 4; j++) begin
      n = {1'b0, i, 2'(j)};
      r[8*(3-j) +: 8] = 8'(n * 8'd7);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sm4_ctrl.sv =====
module sm4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sm4_pkg::dp_stat_t stat,
  output sm4_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEYX = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]    state, state_next;
  sm4_pkg::cnt_t cnt, cnt_next;
  logic          keys_current, keys_current_next;
  logic          out_valid_next;
  logic          out_free;

  assign out_free = ~out_valid | out_ready;
  assign in_ready = (state == ST_IDLE) & keys_current;

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    keys_current_next = keys_current;
    cmd               = '0;
    cmd.cnt           = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid & in_ready) begin
          cmd.load_block = 1'b1;
          cnt_next       = '0;
          state_next     = ST_RUN;
        end else if (~keys_current & ~stat.key_written) begin
          cmd.load_key = 1'b1;
          cnt_next     = '0;
          state_next   = ST_KEYX;
        end
      end
      ST_KEYX: begin
        if (stat.key_written) begin
          state_next = ST_IDLE;
        end else begin
          cmd.round_en = 1'b1;
          cmd.key_mode = 1'b1;
          cnt_next     = cnt + 1'b1;
          if (cnt == sm4_pkg::LAST_ROUND) begin
            keys_current_next = 1'b1;
            state_next        = ST_IDLE;
          end
        end
      end
      ST_RUN: begin
        if (cnt != sm4_pkg::LAST_ROUND) begin
          cmd.round_en = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else if (out_free) begin
          cmd.round_en = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (stat.key_written) begin
      keys_current_next = 1'b0;
    end
  end

  assign out_valid_next = cmd.out_load | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      keys_current <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      keys_current <= keys_current_next;
      out_valid    <= out_valid_next;
    end
  end

endmodule

// ===== rtl/sm4_dp.sv =====
module sm4_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  sm4_pkg::cfg_idx_t   cfg_index,
  input  sm4_pkg::word_t      cfg_data,
  input  logic                decrypt,
  input  sm4_pkg::word_t      block_word0,
  input  sm4_pkg::word_t      block_word1,
  input  sm4_pkg::word_t      block_word2,
  input  sm4_pkg::word_t      block_word3,
  output sm4_pkg::word_t      result_word0,
  output sm4_pkg::word_t      result_word1,
  output sm4_pkg::word_t      result_word2,
  output sm4_pkg::word_t      result_word3,
  input  sm4_pkg::dp_cmd_t    cmd,
  output sm4_pkg::dp_stat_t   stat
);

  sm4_pkg::word_t key [4];
  sm4_pkg::word_t x [4];
  sm4_pkg::word_t rk_store [sm4_pkg::RoundCount];
  logic           dec;
  sm4_pkg::cnt_t  rk_idx;
  sm4_pkg::word_t rk;
  sm4_pkg::word_t t_in;
  sm4_pkg::word_t s;
  sm4_pkg::word_t new_word;

  assign stat.key_written = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        sm4_pkg::CFG_KEY_WORD0: key[0] <= cfg_data;
        sm4_pkg::CFG_KEY_WORD1: key[1] <= cfg_data;
        sm4_pkg::CFG_KEY_WORD2: key[2] <= cfg_data;
        sm4_pkg::CFG_KEY_WORD3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // decryption walks the round keys backward
  assign rk_idx   = dec ? ~cmd.cnt : cmd.cnt;
  assign rk       = cmd.key_mode ? sm4_pkg::ck_word(cmd.cnt) : rk_store[rk_idx];
  assign t_in     = x[1] ^ x[2] ^ x[3] ^ rk;
  assign s        = sm4_pkg::tau(t_in);
  assign new_word = x[0] ^ (cmd.key_mode ? sm4_pkg::l_key(s) : sm4_pkg::l_data(s));

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      for (int i = 0; i < 4; i++) begin
        x[i] <= key[i] ^ sm4_pkg::FK[i];
      end
    end else if (cmd.load_block) begin
      x[0] <= block_word0;
      x[1] <= block_word1;
      x[2] <= block_word2;
      x[3] <= block_word3;
      dec  <= decrypt;
    end else if (cmd.round_en) begin
      x[0] <= x[1];
      x[1] <= x[2];
      x[2] <= x[3];
      x[3] <= new_word;
    end
    if (cmd.round_en & cmd.key_mode) begin
      rk_store[cmd.cnt] <= new_word;
    end
    if (cmd.out_load) begin
      result_word0 <= new_word;
      result_word1 <= x[3];
      result_word2 <= x[2];
      result_word3 <= x[1];
    end
  end

endmodule

// ===== rtl/sm4_block_cipher_top.sv =====
// channel  | handshake            | payload
// in       | in_valid / in_ready  | decrypt, block_word0..3
// out      | out_valid / out_ready| result_word0..3
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (key_word0..3)
//
// a block is accepted and then runs 32 rounds through one shared round unit; its
// s-box stage serves key and data rounds, each with its own linear transform
// after reset or a key write, the round keys are expanded before the next accept
// the last round waits while the previous result beat is still held
// cfg_ready is always high; a key write mid-expansion restarts the expansion
module sm4_block_cipher_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              decrypt,
  input  sm4_pkg::word_t    block_word0,
  input  sm4_pkg::word_t    block_word1,
  input  sm4_pkg::word_t    block_word2,
  input  sm4_pkg::word_t    block_word3,
  output logic              out_valid,
  input  logic              out_ready,
  output sm4_pkg::word_t    result_word0,
  output sm4_pkg::word_t    result_word1,
  output sm4_pkg::word_t    result_word2,
  output sm4_pkg::word_t    result_word3,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  sm4_pkg::cfg_idx_t cfg_index,
  input  sm4_pkg::word_t    cfg_data
);

  sm4_pkg::dp_cmd_t  cmd;
  sm4_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sm4_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .decrypt      (decrypt),
    .block_word0  (block_word0),
    .block_word1  (block_word1),
    .block_word2  (block_word2),
    .block_word3  (block_word3),
    .result_word0 (result_word0),
    .result_word1 (result_word1),
    .result_word2 (result_word2),
    .result_word3 (result_word3),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// ===== rtl/sm4_chk.sv =====
module sm4_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sm4_pkg::word_t    result_word0,
  input sm4_pkg::word_t    result_word3,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // one block at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (in_valid & in_ready) |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // a key write makes the round keys stale, so no block enters next cycle
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid & cfg_ready) |=> !in_ready)
    else $error("block accepted with stale round keys");

  // held result beat keeps its data
  assert property (@(posedge clk) disable iff (rst)
    (out_valid & !out_ready) |=> out_valid && $stable(result_word0) && $stable(result_word3))
    else $error("result beat dropped or changed while stalled");

  assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("handshake active after reset");

endmodule

bind sm4_block_cipher_top sm4_chk u_sm4_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_word0 (result_word0),
  .result_word3 (result_word3),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
